// ===== design/rhse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rhse_pkg;

   // item field widths
   localparam int HASH_W  = 64;
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int QUERY_W = 11;
   localparam int LENO_W  = 11;

   // defaults
   localparam int              MAX_LEN_DEFAULT = 1024;
   localparam logic [HASH_W-1:0] SEED_RESET    = 64'd31;

   // fixed contents of entry zero
   localparam logic [HASH_W-1:0] HASH_ENTRY0  = 64'd0;
   localparam logic [HASH_W-1:0] POWER_ENTRY0 = 64'd1;

   // op codes
   localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // memory strobes from the sequencer
   typedef struct packed {
      logic h_rd;
      logic p_rd;
      logic h_wr;
      logic p_wr;
   } mem_ctrl_type;

endpackage

`default_nettype wire

// ===== design/rhse_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhse_store
   import rhse_pkg::*;
#(
   parameter int DEPTH  = MAX_LEN_DEFAULT + 1,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire mem_ctrl_type      ctl,
   input  wire logic [ADDR_W-1:0] h_rd_addr,
   input  wire logic [ADDR_W-1:0] p_rd_addr,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [HASH_W-1:0] h_wr_data,
   input  wire logic [HASH_W-1:0] p_wr_data,
   output logic      [HASH_W-1:0] h_rd_data,
   output logic      [HASH_W-1:0] p_rd_data
);

   // prefix hashes and seed powers, one read and one write port each
   logic [HASH_W-1:0] hash_mem  [DEPTH];
   logic [HASH_W-1:0] power_mem [DEPTH];

   logic [HASH_W-1:0] h_q_ff;
   logic [HASH_W-1:0] p_q_ff;
   logic              h_zero_ff;
   logic              p_zero_ff;

   always_ff @(posedge clock) begin
      if (ctl.h_wr) begin
         hash_mem[wr_addr] <= h_wr_data;
      end
      if (ctl.p_wr) begin
         power_mem[wr_addr] <= p_wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.h_rd) begin
         h_q_ff    <= hash_mem[h_rd_addr];
         h_zero_ff <= (h_rd_addr == '0);
      end
      if (ctl.p_rd) begin
         p_q_ff    <= power_mem[p_rd_addr];
         p_zero_ff <= (p_rd_addr == '0);
      end
   end

   // entry zero is never written, its value is fixed
   assign h_rd_data = h_zero_ff ? HASH_ENTRY0 : h_q_ff;
   assign p_rd_data = p_zero_ff ? POWER_ENTRY0 : p_q_ff;

endmodule

`default_nettype wire

// ===== design/rhse_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rhse_mul
   import rhse_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [HASH_W-1:0] a,
   input  wire logic [HASH_W-1:0] b,
   output logic                   done,
   output logic      [HASH_W-1:0] product
);

   // low 64 bits of a*b from three 32x32 partial products on one multiplier
   localparam int HALF_W = HASH_W / 2;

   localparam logic [1:0] STEP_LL  = 2'd0;
   localparam logic [1:0] STEP_LH  = 2'd1;
   localparam logic [1:0] STEP_HL  = 2'd2;
   localparam logic [1:0] STEP_END = 2'd3;

   logic              busy_ff;
   logic              done_ff;
   logic [1:0]        step_ff;
   logic [HASH_W-1:0] a_ff;
   logic [HASH_W-1:0] b_ff;
   logic [HASH_W-1:0] prod_ff;
   logic [HASH_W-1:0] acc_ff;

   logic [HALF_W-1:0] x_in;
   logic [HALF_W-1:0] y_in;
   logic [HASH_W-1:0] prod_in;

   assign x_in    = (step_ff == STEP_HL) ? a_ff[HASH_W-1:HALF_W] : a_ff[HALF_W-1:0];
   assign y_in    = (step_ff == STEP_LH) ? b_ff[HASH_W-1:HALF_W] : b_ff[HALF_W-1:0];
   assign prod_in = HASH_W'(x_in) * HASH_W'(y_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= STEP_LL;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_LL;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == STEP_END) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
         case (step_ff)
            STEP_LH: begin
               acc_ff <= prod_ff;
            end
            STEP_HL, STEP_END: begin
               acc_ff[HASH_W-1:HALF_W] <= acc_ff[HASH_W-1:HALF_W] + prod_ff[HALF_W-1:0];
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("multiply started while busy");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && ($past(step_ff) == STEP_END))
      else $error("multiply done without final step");

endmodule

`default_nettype wire

// ===== design/rolling_hash_substring_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake               payload
// req      in   req_valid / req_stall   req_op, req_char_code, req_query_left, req_query_right
// rsp      out  rsp_valid / rsp_stall   rsp_hash_value, rsp_status, rsp_current_length
// csr      in   csr_valid / csr_ready   csr_multiplier_seed
//
// one item at a time; append and query take longer than restart or an unused op
// since they use the shared 32x32 multiplier, three partial products per 64-bit product,
// and the registered read of the hash and power memories
// synchronous reset; entry zero of both memories is fixed, so no clearing pass
// a result waits in the rsp register while the next item is taken; the block
// only holds a new result back when that register is still stalled

module rolling_hash_substring_engine_top
   import rhse_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,

   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [OP_W-1:0]    req_op,
   input  wire logic [CHAR_W-1:0]  req_char_code,
   input  wire logic [QUERY_W-1:0] req_query_left,
   input  wire logic [QUERY_W-1:0] req_query_right,

   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [HASH_W-1:0]  rsp_hash_value,
   output logic                    rsp_status,
   output logic      [LENO_W-1:0]  rsp_current_length,

   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [HASH_W-1:0]  csr_multiplier_seed
);

   localparam int DEPTH = MAX_LEN + 1;
   localparam int LEN_W = $clog2(MAX_LEN + 1);
   // compare width covers both the stored length and the query fields
   localparam int CMP_W = ((LEN_W > QUERY_W) ? LEN_W : QUERY_W) + 1;

   localparam logic [HASH_W-1:0] CHAR_BIAS = 64'd96;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APP_RD,
      ST_APP_MUL_H,
      ST_APP_MUL_P,
      ST_Q_RD2,
      ST_Q_MUL,
      ST_DONE
   } state_type;

   state_type         state_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [HASH_W-1:0] seed_ff;
   logic [HASH_W-1:0] code_ff;
   logic [LEN_W-1:0]  r_addr_ff;
   logic [HASH_W-1:0] res_hash_ff;
   logic              res_status_ff;
   logic              rsp_valid_ff;
   logic [HASH_W-1:0] rsp_hash_ff;
   logic              rsp_status_ff;
   logic [LENO_W-1:0] rsp_len_ff;

   // store and multiplier hookup
   mem_ctrl_type      mem_ctl;
   logic [LEN_W-1:0]  h_rd_addr;
   logic [LEN_W-1:0]  p_rd_addr;
   logic [LEN_W-1:0]  wr_addr;
   logic [HASH_W-1:0] h_rd_data;
   logic [HASH_W-1:0] p_rd_data;
   logic [HASH_W-1:0] app_hash_in;
   logic              mul_start;
   logic [HASH_W-1:0] mul_a;
   logic [HASH_W-1:0] mul_b;
   logic              mul_done;
   logic [HASH_W-1:0] mul_product;

   // request decode
   logic              accept;
   logic [CMP_W-1:0]  l_ext;
   logic [CMP_W-1:0]  r_ext;
   logic [CMP_W-1:0]  len_ext;
   logic [CMP_W-1:0]  l_minus1;
   logic [CMP_W-1:0]  span;
   logic              q_ok;
   logic              full;
   logic [LEN_W-1:0]  len_inc;
   logic              rsp_load;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign l_ext    = CMP_W'(req_query_left);
   assign r_ext    = CMP_W'(req_query_right);
   assign len_ext  = CMP_W'(len_ff);
   assign l_minus1 = l_ext - CMP_W'(1);
   assign span     = r_ext - l_ext + CMP_W'(1);
   // l >= 1, l <= r, r within the stored string
   assign q_ok     = (l_ext != '0) && (l_ext <= r_ext) && (r_ext <= len_ext)
                     && (r_ext <= CMP_W'(MAX_LEN));
   assign full     = (len_ff == LEN_W'(MAX_LEN));
   assign len_inc  = len_ff + LEN_W'(1);

   // finished result moves into the rsp register once that register is free
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign wr_addr     = len_inc;
   assign app_hash_in = mul_product + code_ff;

   // memory and multiplier strobes
   always_comb begin
      mem_ctl   = '0;
      h_rd_addr = len_ff;
      p_rd_addr = len_ff;
      mul_start = 1'b0;
      mul_a     = h_rd_data;
      mul_b     = seed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_APPEND) && !full) begin
               // read h[n] and p[n]
               mem_ctl.h_rd = 1'b1;
               mem_ctl.p_rd = 1'b1;
            end else if (accept && (req_op == OP_QUERY) && q_ok) begin
               // read h[l-1] and p[r-l+1]
               mem_ctl.h_rd = 1'b1;
               mem_ctl.p_rd = 1'b1;
               h_rd_addr    = l_minus1[LEN_W-1:0];
               p_rd_addr    = span[LEN_W-1:0];
            end
         end
         ST_APP_RD: begin
            mul_start = 1'b1;
         end
         ST_APP_MUL_H: begin
            if (mul_done) begin
               mem_ctl.h_wr = 1'b1;
               mul_start    = 1'b1;
               mul_a        = p_rd_data;
            end
         end
         ST_APP_MUL_P: begin
            mem_ctl.p_wr = mul_done;
         end
         ST_Q_RD2: begin
            // h[l-1]*p[r-l+1] while h[r] is fetched
            mul_start    = 1'b1;
            mul_b        = p_rd_data;
            mem_ctl.h_rd = 1'b1;
            h_rd_addr    = r_addr_ff;
         end
         ST_Q_MUL, ST_DONE: begin
            mul_start = 1'b0;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // sequencer, length and seed registers, result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         seed_ff      <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            seed_ff <= csr_multiplier_seed;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  code_ff   <= HASH_W'(req_char_code) - CHAR_BIAS;
                  r_addr_ff <= r_ext[LEN_W-1:0];
                  unique case (req_op)
                     OP_APPEND: begin
                        if (full) begin
                           res_hash_ff   <= '0;
                           res_status_ff <= STATUS_ERR;
                           state_ff      <= ST_DONE;
                        end else begin
                           state_ff <= ST_APP_RD;
                        end
                     end
                     OP_QUERY: begin
                        if (q_ok) begin
                           state_ff <= ST_Q_RD2;
                        end else begin
                           res_hash_ff   <= '0;
                           res_status_ff <= STATUS_ERR;
                           state_ff      <= ST_DONE;
                        end
                     end
                     OP_RESTART: begin
                        len_ff        <= '0;
                        res_hash_ff   <= '0;
                        res_status_ff <= STATUS_OK;
                        state_ff      <= ST_DONE;
                     end
                     default: begin
                        // unused op: report the length, change nothing
                        res_hash_ff   <= '0;
                        res_status_ff <= STATUS_OK;
                        state_ff      <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_APP_RD: begin
               state_ff <= ST_APP_MUL_H;
            end
            ST_APP_MUL_H: begin
               if (mul_done) begin
                  res_hash_ff <= app_hash_in;
                  state_ff    <= ST_APP_MUL_P;
               end
            end
            ST_APP_MUL_P: begin
               if (mul_done) begin
                  len_ff        <= len_inc;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= ST_DONE;
               end
            end
            ST_Q_RD2: begin
               state_ff <= ST_Q_MUL;
            end
            ST_Q_MUL: begin
               if (mul_done) begin
                  // h[r] - h[l-1]*p[r-l+1]
                  res_hash_ff   <= h_rd_data - mul_product;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hand over once the result register is free
               if (rsp_load) begin
                  rsp_hash_ff   <= res_hash_ff;
                  rsp_status_ff <= res_status_ff;
                  rsp_len_ff    <= len_ext[LENO_W-1:0];
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hash_value     = rsp_hash_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_current_length = rsp_len_ff;

   rhse_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (LEN_W)
   ) u_store (
      .clock     (clock),
      .ctl       (mem_ctl),
      .h_rd_addr (h_rd_addr),
      .p_rd_addr (p_rd_addr),
      .wr_addr   (wr_addr),
      .h_wr_data (app_hash_in),
      .p_wr_data (mul_product),
      .h_rd_data (h_rd_data),
      .p_rd_data (p_rd_data)
   );

   rhse_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_product)
   );

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_LEN))
      else $error("stored length beyond capacity");

   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      (mem_ctl.h_wr || mem_ctl.p_wr) |-> (wr_addr != '0) && !full)
      else $error("write to fixed entry or past capacity");

   a_len_step: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.p_wr |=> (len_ff == LEN_W'($past(len_ff) + LEN_W'(1))))
      else $error("append did not advance length");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_ERR)) |-> (rsp_hash_value == '0))
      else $error("error result with nonzero hash");

endmodule

`default_nettype wire
